// File: design/tagged_field_stream_decoder_core_macros.svh
// Assertion macros used by the decoder checker.
`ifndef TAGGED_FIELD_STREAM_DECODER_CORE_MACROS_SVH
`define TAGGED_FIELD_STREAM_DECODER_CORE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define TFSD_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tfsd check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define TFSD_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tfsd check failed");

`endif

// File: design/tfsd_pkg.sv
// Types, codes and constants of the tagged field stream decoder.
package tfsd_pkg;

   localparam logic [7:0] MAX_CHANNELS = 8'd32;
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   localparam logic [7:0] TAG_TEXT      = 8'h74;
   localparam logic [7:0] TAG_NULLSTR   = 8'h4E;
   localparam logic [7:0] TAG_U32       = 8'h4C;
   localparam logic [7:0] TAG_U8        = 8'h42;
   localparam logic [7:0] TAG_U64       = 8'h52;
   localparam logic [7:0] TAG_MICROSEC  = 8'h55;
   localparam logic [7:0] TAG_TIMESTAMP = 8'h54;
   localparam logic [7:0] TAG_SPEC      = 8'h61;
   localparam logic [7:0] TAG_ARB       = 8'h78;
   localparam logic [7:0] TAG_TRUE      = 8'h31;
   localparam logic [7:0] TAG_FALSE     = 8'h30;
   localparam logic [7:0] TAG_MAP       = 8'h6D;
   localparam logic [7:0] TAG_VOLUME    = 8'h76;

   typedef enum logic [3:0] {
      K_STRCHAR = 4'd0,
      K_NULLSTR = 4'd1,
      K_U32     = 4'd2,
      K_U8      = 4'd3,
      K_SPEC    = 4'd4,
      K_ARBLEN  = 4'd5,
      K_ARBBYTE = 4'd6,
      K_BOOL    = 4'd7,
      K_TIMEVAL = 4'd8,
      K_USEC    = 4'd9,
      K_U64     = 4'd10,
      K_MAPCNT  = 4'd11,
      K_MAPENT  = 4'd12,
      K_VOLCNT  = 4'd13,
      K_VOLVAL  = 4'd14,
      K_ERROR   = 4'd15
   } item_kind_type;

   typedef enum logic [1:0] {
      ERR_NONE      = 2'd0,
      ERR_BAD_TAG   = 2'd1,
      ERR_TRUNCATED = 2'd2,
      ERR_CHANNELS  = 2'd3
   } err_code_type;

   typedef enum logic [3:0] {
      TC_NULLSTR,
      TC_TRUE,
      TC_FALSE,
      TC_STRING,
      TC_U32,
      TC_U8,
      TC_U64,
      TC_USEC,
      TC_TIMEVAL,
      TC_SPEC,
      TC_ARB,
      TC_MAP,
      TC_VOLUME,
      TC_BAD
   } tag_class_type;

   typedef enum logic [2:0] {
      PH_TAG,
      PH_STR,
      PH_WORD,
      PH_ARB,
      PH_MAPCNT,
      PH_MAPENT,
      PH_VOLCNT
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       buffer_end;
   } req_payload_type;

   typedef struct packed {
      item_kind_type item_kind;
      logic [63:0]   item_value;
      logic [31:0]   element_index;
      logic          field_done;
      err_code_type  error_code;
   } rsp_payload_type;

   // One classified byte as it waits between front and back.
   typedef struct packed {
      logic [7:0]    data_byte;
      logic          buffer_end;
      tag_class_type tag_class;
      logic          is_zero;
      logic          over_limit;
   } queue_entry_type;

endpackage

// File: design/tfsd_front.sv
// Front end: takes input transactions and classifies each byte.
module tfsd_front
   import tfsd_pkg::*;
(
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_data,
   input  logic            queue_ready,
   output logic            push_valid,
   output queue_entry_type push_entry
);

   tag_class_type tag_class;

   always_comb begin
      unique case (req_data.data_byte)
         TAG_NULLSTR:   tag_class = TC_NULLSTR;
         TAG_TRUE:      tag_class = TC_TRUE;
         TAG_FALSE:     tag_class = TC_FALSE;
         TAG_TEXT:      tag_class = TC_STRING;
         TAG_U32:       tag_class = TC_U32;
         TAG_U8:        tag_class = TC_U8;
         TAG_U64:       tag_class = TC_U64;
         TAG_MICROSEC:  tag_class = TC_USEC;
         TAG_TIMESTAMP: tag_class = TC_TIMEVAL;
         TAG_SPEC:      tag_class = TC_SPEC;
         TAG_ARB:       tag_class = TC_ARB;
         TAG_MAP:       tag_class = TC_MAP;
         TAG_VOLUME:    tag_class = TC_VOLUME;
         default:       tag_class = TC_BAD;
      endcase
   end

   assign req_ready  = queue_ready;
   assign push_valid = req_valid;

   assign push_entry.data_byte  = req_data.data_byte;
   assign push_entry.buffer_end = req_data.buffer_end;
   assign push_entry.tag_class  = tag_class;
   assign push_entry.is_zero    = (req_data.data_byte == 8'd0);
   assign push_entry.over_limit = (req_data.data_byte > MAX_CHANNELS);

endmodule

// File: design/tfsd_queue.sv
// Short queue of classified bytes between front and back.
module tfsd_queue
   import tfsd_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            push_valid,
   output logic            push_ready,
   input  queue_entry_type push_entry,
   output logic            pop_valid,
   input  logic            pop,
   output queue_entry_type pop_entry
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   queue_entry_type store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = store_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// File: design/tfsd_back.sv
// Back end: field parser and result register.
module tfsd_back
   import tfsd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            pop_valid,
   output logic            pop,
   input  queue_entry_type pop_entry,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_data
);

   phase_type       phase_ff, phase_in;
   item_kind_type   field_kind_ff, field_kind_in;
   logic [3:0]      byte_in_word_ff, byte_in_word_in;
   logic [63:0]     acc_ff, acc_in;
   logic [31:0]     left_ff, left_in;
   logic [31:0]     count_ff, count_in;
   logic            discard_ff, discard_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff, rsp_data_in;

   logic            step;
   logic            res_valid;
   rsp_payload_type res;
   logic            fail;
   logic [7:0]      b;
   logic            last;
   logic [63:0]     acc_shift;
   logic [3:0]      bw_dec;
   logic [31:0]     left_dec;
   logic [31:0]     count_inc;
   logic            word_full;
   logic            list_more;

   function automatic rsp_payload_type error_rsp(err_code_type code);
      rsp_payload_type r;
      r = '0;
      r.item_kind  = K_ERROR;
      r.field_done = 1'b1;
      r.error_code = code;
      return r;
   endfunction

   function automatic rsp_payload_type item_rsp(item_kind_type kind, logic [63:0] value,
                                                logic [31:0] index, logic done);
      rsp_payload_type r;
      r = '0;
      r.item_kind     = kind;
      r.item_value    = value;
      r.element_index = index;
      r.field_done    = done;
      r.error_code    = ERR_NONE;
      return r;
   endfunction

   assign step      = pop_valid && (!rsp_valid_ff || rsp_ready);
   assign pop       = step;
   assign b         = pop_entry.data_byte;
   assign last      = pop_entry.buffer_end;
   assign acc_shift = {acc_ff[55:0], b};
   assign bw_dec    = byte_in_word_ff - 4'd1;
   assign left_dec  = left_ff - 32'd1;
   assign count_inc = count_ff + 32'd1;
   assign word_full = (bw_dec == 4'd0);
   assign list_more = (left_dec != 32'd0);
   assign fail      = res_valid && (res.item_kind == K_ERROR);

   // Result of the byte at the head of the queue.
   always_comb begin
      res_valid = 1'b0;
      res       = '0;
      if (!discard_ff) begin
         unique case (phase_ff)
            PH_TAG: begin
               case (pop_entry.tag_class)
                  TC_NULLSTR: begin
                     res_valid = 1'b1;
                     res = item_rsp(K_NULLSTR, 64'd0, 32'd0, 1'b1);
                  end
                  TC_TRUE: begin
                     res_valid = 1'b1;
                     res = item_rsp(K_BOOL, 64'd1, 32'd0, 1'b1);
                  end
                  TC_FALSE: begin
                     res_valid = 1'b1;
                     res = item_rsp(K_BOOL, 64'd0, 32'd0, 1'b1);
                  end
                  TC_BAD: begin
                     res_valid = 1'b1;
                     res = error_rsp(ERR_BAD_TAG);
                  end
                  default: begin
                     if (last) begin
                        res_valid = 1'b1;
                        res = error_rsp(ERR_TRUNCATED);
                     end
                  end
               endcase
            end
            PH_STR: begin
               res_valid = 1'b1;
               if (pop_entry.is_zero) begin
                  res = item_rsp(K_STRCHAR, 64'd0, count_ff, 1'b1);
               end else if (last) begin
                  res = error_rsp(ERR_TRUNCATED);
               end else begin
                  res = item_rsp(K_STRCHAR, {56'd0, b}, count_ff, 1'b0);
               end
            end
            PH_WORD: begin
               if (!word_full) begin
                  if (last) begin
                     res_valid = 1'b1;
                     res = error_rsp(ERR_TRUNCATED);
                  end
               end else begin
                  res_valid = 1'b1;
                  if (field_kind_ff == K_ARBLEN) begin
                     if (acc_shift[31:0] == 32'd0) begin
                        res = item_rsp(K_ARBLEN, 64'd0, 32'd0, 1'b1);
                     end else if (last) begin
                        res = error_rsp(ERR_TRUNCATED);
                     end else begin
                        res = item_rsp(K_ARBLEN, {32'd0, acc_shift[31:0]}, 32'd0, 1'b0);
                     end
                  end else if (field_kind_ff == K_VOLVAL) begin
                     if (list_more && last) begin
                        res = error_rsp(ERR_TRUNCATED);
                     end else begin
                        res = item_rsp(K_VOLVAL, {32'd0, acc_shift[31:0]}, count_ff,
                                       !list_more);
                     end
                  end else begin
                     res = item_rsp(field_kind_ff, acc_shift, 32'd0, 1'b1);
                  end
               end
            end
            PH_ARB, PH_MAPENT: begin
               res_valid = 1'b1;
               if (list_more && last) begin
                  res = error_rsp(ERR_TRUNCATED);
               end else begin
                  res = item_rsp((phase_ff == PH_ARB) ? K_ARBBYTE : K_MAPENT,
                                 {56'd0, b}, count_ff, !list_more);
               end
            end
            PH_MAPCNT, PH_VOLCNT: begin
               res_valid = 1'b1;
               if (pop_entry.over_limit) begin
                  res = error_rsp(ERR_CHANNELS);
               end else if (pop_entry.is_zero) begin
                  res = item_rsp((phase_ff == PH_MAPCNT) ? K_MAPCNT : K_VOLCNT,
                                 64'd0, 32'd0, 1'b1);
               end else if (last) begin
                  res = error_rsp(ERR_TRUNCATED);
               end else begin
                  res = item_rsp((phase_ff == PH_MAPCNT) ? K_MAPCNT : K_VOLCNT,
                                 {56'd0, b}, 32'd0, 1'b0);
               end
            end
            default: begin
               res_valid = 1'b0;
            end
         endcase
      end
   end

   // Parse state update for the byte at the head of the queue.
   always_comb begin
      phase_in        = phase_ff;
      field_kind_in   = field_kind_ff;
      byte_in_word_in = byte_in_word_ff;
      acc_in          = acc_ff;
      left_in         = left_ff;
      count_in        = count_ff;
      discard_in      = discard_ff;
      if (step) begin
         if (discard_ff) begin
            phase_in = PH_TAG;
         end else if (fail) begin
            discard_in = 1'b1;
            phase_in   = PH_TAG;
         end else begin
            unique case (phase_ff)
               PH_TAG: begin
                  acc_in = 64'd0;
                  case (pop_entry.tag_class)
                     TC_STRING: begin
                        phase_in = PH_STR;
                        count_in = 32'd0;
                     end
                     TC_MAP:    phase_in = PH_MAPCNT;
                     TC_VOLUME: phase_in = PH_VOLCNT;
                     TC_U32: begin
                        phase_in = PH_WORD; field_kind_in = K_U32; byte_in_word_in = 4'd4;
                     end
                     TC_U8: begin
                        phase_in = PH_WORD; field_kind_in = K_U8; byte_in_word_in = 4'd1;
                     end
                     TC_U64: begin
                        phase_in = PH_WORD; field_kind_in = K_U64; byte_in_word_in = 4'd8;
                     end
                     TC_USEC: begin
                        phase_in = PH_WORD; field_kind_in = K_USEC; byte_in_word_in = 4'd8;
                     end
                     TC_TIMEVAL: begin
                        phase_in = PH_WORD; field_kind_in = K_TIMEVAL;
                        byte_in_word_in = 4'd8;
                     end
                     TC_SPEC: begin
                        phase_in = PH_WORD; field_kind_in = K_SPEC; byte_in_word_in = 4'd6;
                     end
                     TC_ARB: begin
                        phase_in = PH_WORD; field_kind_in = K_ARBLEN;
                        byte_in_word_in = 4'd4;
                     end
                     default: phase_in = PH_TAG;
                  endcase
               end
               PH_STR: begin
                  if (pop_entry.is_zero) begin
                     phase_in = PH_TAG;
                  end else begin
                     count_in = count_inc;
                  end
               end
               PH_WORD: begin
                  acc_in          = acc_shift;
                  byte_in_word_in = bw_dec;
                  if (word_full) begin
                     if (field_kind_ff == K_ARBLEN) begin
                        if (acc_shift[31:0] == 32'd0) begin
                           phase_in = PH_TAG;
                        end else begin
                           left_in  = acc_shift[31:0];
                           count_in = 32'd0;
                           phase_in = PH_ARB;
                        end
                     end else if (field_kind_ff == K_VOLVAL) begin
                        left_in  = left_dec;
                        count_in = count_inc;
                        if (list_more) begin
                           byte_in_word_in = 4'd4;
                           acc_in          = 64'd0;
                        end else begin
                           phase_in = PH_TAG;
                        end
                     end else begin
                        phase_in = PH_TAG;
                     end
                  end
               end
               PH_ARB, PH_MAPENT: begin
                  left_in  = left_dec;
                  count_in = count_inc;
                  if (!list_more) begin
                     phase_in = PH_TAG;
                  end
               end
               PH_MAPCNT, PH_VOLCNT: begin
                  if (pop_entry.is_zero) begin
                     phase_in = PH_TAG;
                  end else begin
                     left_in  = {24'd0, b};
                     count_in = 32'd0;
                     if (phase_ff == PH_MAPCNT) begin
                        phase_in = PH_MAPENT;
                     end else begin
                        phase_in        = PH_WORD;
                        field_kind_in   = K_VOLVAL;
                        byte_in_word_in = 4'd4;
                        acc_in          = 64'd0;
                     end
                  end
               end
               default: phase_in = PH_TAG;
            endcase
         end
         // A flagged byte always closes the buffer.
         if (last) begin
            phase_in   = PH_TAG;
            discard_in = 1'b0;
         end
      end
   end

   // Result register: load on a step, drop once taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (step) begin
         rsp_valid_in = res_valid;
         rsp_data_in  = res;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_TAG;
         field_kind_ff   <= K_STRCHAR;
         byte_in_word_ff <= 4'd0;
         acc_ff          <= 64'd0;
         left_ff         <= 32'd0;
         count_ff        <= 32'd0;
         discard_ff      <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         phase_ff        <= phase_in;
         field_kind_ff   <= field_kind_in;
         byte_in_word_ff <= byte_in_word_in;
         acc_ff          <= acc_in;
         left_ff         <= left_in;
         count_ff        <= count_in;
         discard_ff      <= discard_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: design/tagged_field_stream_decoder_core.sv
// Top level of the tagged field stream decoder.
//
//   channel   direction  payload             transaction
//   req_      in         data_byte, end flag one buffer byte
//   rsp_      out        kind, value, index  zero or one result per byte
//
// Throughput: one byte per cycle, sustained, while rsp_ready stays high.
// A byte lands in the queue when it is accepted; the parser step that takes
// it from the queue loads the result register, which drives rsp_.
// The parser does one byte per cycle unless a held result stalls it; the result register sets the pace.
// Reset clears the queue, the parse state and the result valid flag.
// A held result stalls the parser; the queue then fills and req_ready drops.
module tagged_field_stream_decoder_core
   import tfsd_pkg::*;
#(
   // Entries of the byte queue between front and back (2 or more).
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_data
);

   logic            push_valid;
   logic            push_ready;
   queue_entry_type push_entry;
   logic            pop_valid;
   logic            pop;
   queue_entry_type pop_entry;

   // Classify each byte as it arrives (tag decode, zero and channel checks).
   tfsd_front u_front (
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .queue_ready (push_ready),
      .push_valid  (push_valid),
      .push_entry  (push_entry)
   );

   // Hold classified bytes so the front keeps taking transactions while
   // the back waits on the result channel.
   tfsd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop        (pop),
      .pop_entry  (pop_entry)
   );

   // Advance the field parser one byte per step and register its result.
   tfsd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop       (pop),
      .pop_entry (pop_entry),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// File: design/tfsd_checker.sv
// Port-level checks of the decoder, bound to the top level.
`include "tagged_field_stream_decoder_core_macros.svh"

module tfsd_checker
   import tfsd_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_ready,
   input req_payload_type req_data,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input rsp_payload_type rsp_data
);

   `TFSD_ASSERT_NXT(a_req_hold, clock, reset, req_valid && !req_ready, req_valid && $stable(req_data))

   `TFSD_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

   `TFSD_ASSERT_IMP(a_err_shape, clock, reset, rsp_valid && rsp_data.item_kind == K_ERROR, rsp_data.item_value == 64'd0 && rsp_data.element_index == 32'd0 && rsp_data.field_done && rsp_data.error_code != ERR_NONE)

   `TFSD_ASSERT_IMP(a_ok_code, clock, reset, rsp_valid && rsp_data.item_kind != K_ERROR, rsp_data.error_code == ERR_NONE)

   `TFSD_ASSERT_IMP(a_str_term, clock, reset, rsp_valid && rsp_data.item_kind == K_STRCHAR, rsp_data.field_done == (rsp_data.item_value == 64'd0))

endmodule

bind tagged_field_stream_decoder_core tfsd_checker u_tfsd_checker (.*);
